// File: rtl/lzss_pkg.sv
// Package: shared constants, types and the slot hash for the zero-sum run finder.
`timescale 1ns / 1ps

package lzss_pkg;

    localparam int ELEM_W    = 32;                   // element width on the stream
    localparam int MAX_LEN   = 4096;                 // elements counted per array
    localparam int TBL_DEPTH = 8192;                 // hash table slots
    localparam int SUM_W     = 44;                   // prefix sum, never wraps
    localparam int POS_W     = $clog2(MAX_LEN + 1);  // position, can reach MAX_LEN
    localparam int FPOS_W    = $clog2(MAX_LEN);      // stored first position
    localparam int LEN_W     = 13;                   // result length field
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int EPOCH_W   = 8;                    // array generation tag per slot

    typedef enum logic [2:0] {
        S_CLEAR,   // sweep writes epoch zero into every slot
        S_IDLE,    // waiting for an element
        S_PROBE,   // slot data back from table, compare and step
        S_EMIT     // hand the result to the output register
    } t_state;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [SUM_W-1:0]   key;
        logic [FPOS_W-1:0]  fpos;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        t_entry             wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_mem_req;

    typedef struct packed {
        logic               valid;
        logic [LEN_W-1:0]   length;
        logic               exceeded;
    } t_result;

    // Folds the sign-extended 64-bit key; the low address bits pick the home slot.
    function automatic logic [ADDR_W-1:0] f_hash(input logic [SUM_W-1:0] key);
        logic [63:0] k;
        logic [63:0] h;
        k = {{(64 - SUM_W){key[SUM_W-1]}}, key};
        h = k ^ (k >> 13) ^ (k >> 29) ^ (k >> 47);
        return h[ADDR_W-1:0];
    endfunction

endpackage

// File: rtl/lzss_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module lzss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lzss_probe.sv
// Probe engine: prefix sum, linear probing over the slot table, epoch sweep.
`timescale 1ns / 1ps

module lzss_probe (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [lzss_pkg::ELEM_W-1:0] i_elem,
    input  logic                        i_last,
    output logic                        o_ready,
    output lzss_pkg::t_mem_req          o_mem,
    input  lzss_pkg::t_entry            i_rdata,
    output lzss_pkg::t_result           o_result,
    input  logic                        i_result_ready
);

    import lzss_pkg::*;

    t_state             r_state, n_state;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [LEN_W-1:0]   r_best, n_best;
    logic               r_ovf, n_ovf;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0]  r_clr, n_clr;
    logic               r_last, n_last;

    logic               accept;
    logic               in_range;
    logic [SUM_W-1:0]   acc_sum;
    logic               slot_live;
    logic               key_hit;
    logic [POS_W-1:0]   run_len;
    logic               clr_done;
    logic               epoch_top;

    assign accept    = (r_state == S_IDLE) && i_valid;
    assign in_range  = r_pos < POS_W'(MAX_LEN);
    assign acc_sum   = r_sum + {{(SUM_W - ELEM_W){i_elem[ELEM_W-1]}}, i_elem};
    assign slot_live = i_rdata.epoch == r_epoch;
    assign key_hit   = slot_live && (i_rdata.key == r_sum);
    assign run_len   = r_pos - {{(POS_W - FPOS_W){1'b0}}, i_rdata.fpos};
    assign clr_done  = r_clr == {ADDR_W{1'b1}};
    assign epoch_top = r_epoch == {EPOCH_W{1'b1}};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    if (in_range && acc_sum != '0) n_state = S_PROBE;
                    else if (i_last)              n_state = S_EMIT;
                end
            end
            S_PROBE: begin
                if (!slot_live || key_hit) n_state = r_last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_result_ready) n_state = epoch_top ? S_CLEAR : S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_sum    = r_sum;
        n_pos    = r_pos;
        n_best   = r_best;
        n_ovf    = r_ovf;
        n_epoch  = r_epoch;
        n_idx    = r_idx;
        n_clr    = r_clr;
        n_last   = r_last;
        o_ready  = 1'b0;
        o_mem    = '0;
        o_result = '0;
        case (r_state)
            S_CLEAR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (clr_done) n_epoch = EPOCH_W'(1);
            end
            S_IDLE: begin
                o_ready     = 1'b1;
                o_mem.raddr = f_hash(acc_sum);
                if (accept) begin
                    n_last = i_last;
                    if (!in_range) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_sum = acc_sum;
                        n_idx = f_hash(acc_sum);
                        if (acc_sum == '0) begin
                            n_best = LEN_W'(r_pos + 1'b1);
                            n_pos  = r_pos + 1'b1;
                        end
                    end
                end
            end
            S_PROBE: begin
                o_mem.raddr = r_idx + 1'b1;
                if (!slot_live) begin
                    // free slot: first sighting of this sum
                    o_mem.we          = 1'b1;
                    o_mem.waddr       = r_idx;
                    o_mem.wdata.epoch = r_epoch;
                    o_mem.wdata.key   = r_sum;
                    o_mem.wdata.fpos  = r_pos[FPOS_W-1:0];
                    n_pos             = r_pos + 1'b1;
                end else if (key_hit) begin
                    if (LEN_W'(run_len) > r_best) n_best = LEN_W'(run_len);
                    n_pos = r_pos + 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_EMIT: begin
                o_result.valid    = 1'b1;
                o_result.length   = r_best;
                o_result.exceeded = r_ovf;
                if (i_result_ready) begin
                    n_sum  = '0;
                    n_pos  = '0;
                    n_best = '0;
                    n_ovf  = 1'b0;
                    n_clr  = '0;
                    if (!epoch_top) n_epoch = r_epoch + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sum   <= '0;
            r_pos   <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
            r_epoch <= EPOCH_W'(1);
            r_clr   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
            r_epoch <= n_epoch;
            r_clr   <= n_clr;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
    end

endmodule

// File: rtl/lzss_out.sv
// Output register: holds one result until the master side takes it.
`timescale 1ns / 1ps

module lzss_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lzss_pkg::t_result          i_result,
    output logic                       o_result_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [lzss_pkg::LEN_W-1:0] o_length,
    output logic                       o_exceeded
);

    import lzss_pkg::*;

    logic             r_valid, n_valid;
    logic [LEN_W-1:0] r_length;
    logic             r_exceeded;

    assign o_result_ready = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_ready) n_valid = 1'b0;
        if (i_result.valid && o_result_ready) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_result.valid && o_result_ready) begin
            r_length   <= i_result.length;
            r_exceeded <= i_result.exceeded;
        end
    end

    assign o_valid    = r_valid;
    assign o_length   = r_length;
    assign o_exceeded = r_exceeded;

endmodule

// File: rtl/longest_zero_sum_subarray.sv
// Top level: longest zero-sum contiguous subarray over a stream of signed elements.
`timescale 1ns / 1ps
//
//  channel  dir   signals                              request carries
//  -------  ----  -----------------------------------  ------------------------------
//  s        in    i_s_tvalid o_s_tready i_s_tdata      one element, tlast on the last
//                 i_s_tlast
//  m        out   o_m_tvalid i_m_tready o_m_tdata      one result per array
//                 o_m_tuser
//
//  Elements: one whose prefix sum is zero, or that falls beyond MAX_LEN, needs no
//  probe; any other then probes slots from its home slot on (one table read per
//  cycle through the single read port) until a free slot or a match ends the run.
//  After the last element of an array the emit state passes the result to the output.
//  Reset: synchronous, active low; afterwards a clearing pass over the 8192 slots tags
//  every slot as empty before the first element is taken. The same pass runs again
//  after every 255th array, when the 8-bit slot epoch runs out.
//  Stalls: the result sits in an output register; the next array's elements are
//  taken while it waits, and a new result waits in the engine only if the old one
//  has still not gone.
//
//  Slots are tagged with the epoch of the array that wrote them; a slot whose tag
//  differs from the current epoch counts as empty, so finishing an array costs no
//  sweep. The table holds at most MAX_LEN sums per array with twice as many slots,
//  so a probe run always ends on a free slot or a match.

module longest_zero_sum_subarray (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] element_value
    input  logic        i_s_tlast,   // last_element
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [12:0] longest_length, [15:13] zero
    output logic        o_m_tuser    // length_exceeded
);

    import lzss_pkg::*;

    t_mem_req          mem_req;
    logic [ENTRY_W-1:0] mem_rdata;
    t_result           result;
    logic              result_ready;
    logic [LEN_W-1:0]  out_length;

    // slot table: epoch, key and first position in one word
    lzss_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    // prefix sum, probing and sequencing
    lzss_probe u_probe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_tvalid),
        .i_elem         (i_s_tdata[ELEM_W-1:0]),
        .i_last         (i_s_tlast),
        .o_ready        (o_s_tready),
        .o_mem          (mem_req),
        .i_rdata        (t_entry'(mem_rdata)),
        .o_result       (result),
        .i_result_ready (result_ready)
    );

    // result register toward the master side
    lzss_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_result       (result),
        .o_result_ready (result_ready),
        .o_valid        (o_m_tvalid),
        .i_ready        (i_m_tready),
        .o_length       (out_length),
        .o_exceeded     (o_m_tuser)
    );

    assign o_m_tdata = {{(16 - LEN_W){1'b0}}, out_length};

endmodule

// File: rtl/lzss_checker.sv
// Port checker for the zero-sum run finder, bound to the top level.
`timescale 1ns / 1ps

module lzss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tuser
);

    // a waiting result stays up
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result request dropped before it was taken");

    // a waiting result holds its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result payload changed while stalled");

    // a run can never be longer than the counted elements
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata <= 16'd4096)
        else $error("result length beyond array limit");

    // a result only appears after the engine has stopped taking elements
    a_emit_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> !$past(i_s_tvalid && o_s_tready))
        else $error("result appeared right after an element request");

endmodule

bind longest_zero_sum_subarray lzss_checker u_lzss_checker (.*);

// File: sim/tb.sv
// Testbench for the streaming longest zero-sum subarray finder.
`timescale 1ns / 1ps

module tb;
    import lzss_pkg::*;

    localparam int     RAND_ITEMS   = 1325;       // random element target
    localparam int     HOLD_CYCLES  = 2000;       // one long receiver hold-off
    localparam int     HOLD_AFTER   = 300;        // elements taken before the hold-off
    localparam int     DRAIN_CYCLES = 200;        // quiet time after the last result
    localparam int     LIMIT_CYCLES = 1_000_000;
    localparam longint CANCEL_LIM   = 64'sd2147483647;

    typedef enum {FILL_SMALL, FILL_MIXED, FILL_WIDE, FILL_EXTREME} t_fill;
    typedef enum {SINK_FREE, SINK_COIN, SINK_SLOW} t_sink_mode;

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } t_elem_item;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             exceeded;
    } t_zero_run;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata    = '0;
    logic        s_tlast    = 1'b0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;

    longest_zero_sum_subarray u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    t_elem_item element_q[$];
    t_zero_run  due_runs[$];

    // running state of the predicted array
    logic [63:0] run_sum;
    int          run_pos;
    int          run_best;
    bit          run_over;
    logic [63:0] slot_sum[int];
    int          slot_first[int];

    int  err_count     = 0;
    int  results_seen  = 0;
    int  over_seen     = 0;
    int  longest_seen  = 0;
    int  elems_taken   = 0;
    int  arrays_queued = 0;
    int  cycle_count   = 0;
    bit  elem_took     = 1'b0;
    int  burst_left    = 0;
    int  gap_left      = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    int  mode_left     = 0;
    t_sink_mode sink_mode = SINK_FREE;
    t_elem_item next_item;
    bit         next_valid = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic int home_slot(input logic [63:0] k);
        logic [63:0] h;
        h = k ^ (k >> 13) ^ (k >> 29) ^ (k >> 47);
        return int'(h % TBL_DEPTH);
    endfunction

    function automatic void clear_run();
        run_sum  = '0;
        run_pos  = 0;
        run_best = 0;
        run_over = 1'b0;
        slot_sum.delete();
        slot_first.delete();
    endfunction

    // Advance the predicted array by one element; on the last one queue the run length.
    task automatic zero_run_step(input logic [31:0] elem, input logic last_flag);
        int        idx;
        int        probes;
        bit        hit;
        bit        stored;
        int        first;
        t_zero_run r;
        hit    = 1'b0;
        stored = 1'b0;
        first  = 0;
        if (run_pos < MAX_LEN) begin
            run_sum = run_sum + {{(64 - ELEM_W){elem[ELEM_W-1]}}, elem[ELEM_W-1:0]};
            if (run_sum == 64'd0) begin
                run_best = run_pos + 1;
            end else begin
                idx = home_slot(run_sum);
                for (probes = 0; probes < TBL_DEPTH && !hit && !stored; probes++) begin
                    if (!slot_sum.exists(idx)) begin
                        slot_sum[idx]   = run_sum;
                        slot_first[idx] = run_pos;
                        stored          = 1'b1;
                    end else if (slot_sum[idx] == run_sum) begin
                        hit   = 1'b1;
                        first = slot_first[idx];
                    end else begin
                        idx = (idx + 1) % TBL_DEPTH;
                    end
                end
                if (!hit && !stored)
                    run_over = 1'b1;    // table full
                if (hit && run_pos - first > run_best)
                    run_best = run_pos - first;
            end
            run_pos++;
        end else begin
            run_over = 1'b1;            // beyond the counted length
        end
        if (last_flag) begin
            r.length   = run_best[LEN_W-1:0];
            r.exceeded = run_over;
            due_runs.push_back(r);
            clear_run();
        end
    endtask

    task automatic flag_result(input string why, input t_zero_run want);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] %s: got len=%0d exc=%0b tdata=%h, want len=%0d exc=%0b",
                     $realtime, why, m_tdata[LEN_W-1:0], m_tuser, m_tdata,
                     want.length, want.exceeded);
    endtask

    task automatic push_elem(input logic [31:0] v, input bit last_flag);
        element_q.push_back('{value: v, last: last_flag});
        if (last_flag)
            arrays_queued++;
    endtask

    task automatic queue_array(input int len, input t_fill fill);
        longint      acc;
        logic [31:0] v;
        int          k;
        acc = 0;
        for (k = 0; k < len; k++) begin
            case (fill)
                FILL_SMALL: begin
                    if ($urandom_range(0, 9) == 0 && acc > -1000 && acc < 1000)
                        v = 32'(-acc);
                    else
                        v = 32'($urandom_range(0, 8)) - 32'd4;
                end
                FILL_MIXED: begin
                    if ($urandom_range(0, 4) == 0 && acc >= -CANCEL_LIM && acc <= CANCEL_LIM)
                        v = 32'(-acc);
                    else if ($urandom_range(0, 1) == 1)
                        v = $urandom;
                    else
                        v = 32'($urandom_range(0, 6)) - 32'd3;
                end
                FILL_WIDE: v = $urandom;
                default: begin
                    case ($urandom_range(0, 4))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7fff_ffff;
                        2:       v = 32'h0000_0000;
                        3:       v = 32'hffff_ffff;
                        default: v = 32'h0000_0001;
                    endcase
                end
            endcase
            acc += longint'($signed(v));
            push_elem(v, k == len - 1);
        end
    endtask

    // Stimulus: directed arrays, then short random arrays.
    initial begin
        int    rand_items;
        int    len;
        int    pick;
        t_fill fill;
        rand_items = 0;
        clear_run();

        push_elem(32'd0, 1'b1);                                     // lone zero: 1
        push_elem(32'd5, 1'b1);                                     // lone nonzero: 0
        push_elem(32'h7fff_ffff, 1'b0);                             // extremes cancel: 3
        push_elem(32'h8000_0000, 1'b0);
        push_elem(32'h0000_0001, 1'b1);
        push_elem(32'h8000_0000, 1'b0);                             // sum down to -2^32: 5
        push_elem(32'h8000_0000, 1'b0);
        push_elem(32'h7fff_ffff, 1'b0);
        push_elem(32'h7fff_ffff, 1'b0);
        push_elem(32'h0000_0002, 1'b1);
        push_elem(32'd3, 1'b0);                                     // repeated sum: 4
        push_elem(32'd4, 1'b0);
        push_elem(-32'sd4, 1'b0);
        push_elem(32'd2, 1'b0);
        push_elem(-32'sd2, 1'b0);
        push_elem(32'd7, 1'b1);
        push_elem(32'd1, 1'b0);                                     // alternating: 4
        push_elem(-32'sd1, 1'b0);
        push_elem(32'd1, 1'b0);
        push_elem(-32'sd1, 1'b1);
        push_elem(32'hffff_ffff, 1'b0);                             // 2
        push_elem(32'h0000_0001, 1'b1);
        push_elem(32'haaaa_aaaa, 1'b0);                             // bit toggles: 0
        push_elem(32'h5555_5555, 1'b1);

        while (rand_items < RAND_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 2);
            else if (pick < 92)
                len = $urandom_range(3, 10);
            else
                len = $urandom_range(11, 40);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                fill = FILL_SMALL;
            else if (pick < 7)
                fill = FILL_MIXED;
            else if (pick < 9)
                fill = FILL_WIDE;
            else
                fill = FILL_EXTREME;
            queue_array(len, fill);
            rand_items += len;
        end

        wait (i_rst_n);
        while (element_q.size() != 0 || s_tvalid)
            @(posedge i_clk);
        while (due_runs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        err_count += due_runs.size();

        $display("summary: %0d arrays, %0d elements taken, %0d results checked",
                 arrays_queued, elems_taken, results_seen);
        $display("summary: %0d over-length results, longest run %0d", over_seen, longest_seen);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_tvalid || elem_took)) begin
            next_item  = '0;
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (element_q.size() != 0) begin
                next_item  = element_q.pop_front();
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            s_tvalid <= next_valid;
            s_tdata  <= next_item.value;
            s_tlast  <= next_item.last;
        end
    end

    // Receiver: a long hold-off once, otherwise a stall pattern that changes mode.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && elems_taken >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    case ($urandom_range(0, 2))
                        0:       sink_mode = SINK_FREE;
                        1:       sink_mode = SINK_COIN;
                        default: sink_mode = SINK_SLOW;
                    endcase
                    mode_left = $urandom_range(32, 400);
                end else begin
                    mode_left--;
                end
                case (sink_mode)
                    SINK_FREE: m_tready <= 1'b1;
                    SINK_COIN: m_tready <= 1'($urandom_range(0, 1));
                    default:   m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Monitor: check results against the oldest expectation, feed accepted elements on.
    always @(posedge i_clk) begin
        t_zero_run want;
        if (i_rst_n) begin
            elem_took <= s_tvalid && s_tready;
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser)
                    over_seen++;
                if (int'(m_tdata[LEN_W-1:0]) > longest_seen)
                    longest_seen = int'(m_tdata[LEN_W-1:0]);
                if (due_runs.size() == 0) begin
                    flag_result("unexpected result", '0);
                end else begin
                    want = due_runs.pop_front();
                    if (m_tdata !== {{(16 - LEN_W){1'b0}}, want.length}
                        || m_tuser !== want.exceeded)
                        flag_result("result mismatch", want);
                end
            end
            if (s_tvalid && s_tready) begin
                elems_taken++;
                zero_run_step(s_tdata, s_tlast);
            end
        end else begin
            elem_took <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb: errors");
            $finish;
        end
    end

endmodule
